### rtl/core/bounded_ordered_list_engine_defines.svh
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BOLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BOLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bole_pkg.sv
`timescale 1ns / 1ps
package bole_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 6;
  localparam int VAL_W    = 32;

  // opcodes
  localparam logic [2:0] OP_ADD_HEAD = 3'd0;
  localparam logic [2:0] OP_ADD_TAIL = 3'd1;
  localparam logic [2:0] OP_INSERT   = 3'd2;
  localparam logic [2:0] OP_DEL_HEAD = 3'd3;
  localparam logic [2:0] OP_DEL_TAIL = 3'd4;
  localparam logic [2:0] OP_READ_OUT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [5:0]              position;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] out_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic             alloc;
    logic [IDX_W-1:0] alloc_idx;
    logic             rel;
    logic [IDX_W-1:0] rel_idx;
  } free_cmd_t;

endpackage

### rtl/core/bole_ram.sv
`timescale 1ns / 1ps
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/bole_free_map.sv
`timescale 1ns / 1ps
module bole_free_map import bole_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  free_cmd_t           cmd,
  output logic [IDX_W-1:0]    free_idx,
  output logic [CAPACITY-1:0] free_vec
);

  logic [CAPACITY-1:0] free_r;
  logic [CAPACITY-1:0] free_nxt;

  always_comb begin
    free_nxt = free_r;
    if (cmd.alloc) begin
      free_nxt[cmd.alloc_idx] = 1'b0;
    end
    if (cmd.rel) begin
      free_nxt[cmd.rel_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
    end else begin
      free_r <= free_nxt;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_vec = free_r;

endmodule

### rtl/core/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// bounded ordered list engine: singly linked list of up to 32 signed values
// input channel (in_valid/in_stall/in_data) carries one operation per transfer:
//   add head, add tail, insert at 1-based position, delete head, delete tail,
//   read out; unknown opcodes answer ok and leave the list alone
// output channel (out_valid/out_stall/out_data) gives one status transfer per
//   operation, or one transfer per element on read out, last flagging the end
// one operation is in flight at a time; in_stall is low only when idle
// from input transfer to result: head adds, unknown opcodes and failures go
//   from decode straight to the response; delete head first reads the head
//   link; insert and add tail walk the link memory one link per cycle, then
//   link and fix the new element; delete tail with two or more elements walks
//   to the one before the tail; read out streams one element per cycle while
//   the receiver does not stall; the next input transfer comes in the cycle
//   after the last result is loaded; the link memory read port sets the rate,
//   slowest for add tail or insert at the end of a 31-element list
// a finished result sits in the output register; a stalled receiver holds it
//   and the engine waits before loading the next one, while idle it still
//   takes the next operation
// reset (rst_n low, synchronous) empties the list and clears both channels;
//   the value and link memories are not cleared; stale links are never followed
module bounded_ordered_list_engine import bole_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "bounded_ordered_list_engine_defines.svh"

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_LINK   = 8'b0000_1000,
    S_FIX    = 8'b0001_0000,
    S_HEAD   = 8'b0010_0000,
    S_RDATA  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // latched operation
  logic [2:0]              op_r;
  logic [5:0]              pos_r;
  logic signed [VAL_W-1:0] val_r;

  // list control
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // walk / read out bookkeeping
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [1:0]       st_r, st_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_ready;
  logic      out_load;

  // memory ports
  logic             lk_we, lk_re, vl_we, vl_re;
  logic [IDX_W-1:0] lk_waddr, lk_raddr, vl_waddr, vl_raddr;
  logic [IDX_W-1:0] lk_wdata, lk_rdata;
  logic [VAL_W-1:0] vl_wdata, vl_rdata;

  // free map
  free_cmd_t           fcmd;
  logic [IDX_W-1:0]    free_idx;
  logic [CAPACITY-1:0] free_vec;

  logic             in_xfer;
  logic             full, empty;
  logic [CNT_W:0]   pos_ext;
  logic [CNT_W:0]   cnt_p1;
  logic [IDX_W-1:0] walk_cur;

  bole_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  bole_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .re    (vl_re),
    .raddr (vl_raddr),
    .rdata (vl_rdata)
  );

  bole_free_map u_free_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (fcmd),
    .free_idx (free_idx),
    .free_vec (free_vec)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign cnt_p1  = {1'b0, count_r} + (CNT_W + 1)'(1);
  // current walk pointer: fresh link data once a read is in flight
  assign walk_cur = rd_pend_r ? lk_rdata : p_r;

  // effective 1-based position for the add/insert family
  always_comb begin
    if (op_r == OP_ADD_HEAD) begin
      pos_ext = (CNT_W + 1)'(1);
    end else if (op_r == OP_ADD_TAIL) begin
      pos_ext = cnt_p1;
    end else begin
      pos_ext = {1'b0, pos_r};
    end
  end

  // sequencer: no memory is read and written in the same cycle, and every write
  // lands before any read of the same slot
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    p_nxt        = p_r;
    steps_nxt    = steps_r;
    rd_pend_nxt  = rd_pend_r;
    n_nxt        = n_r;
    st_nxt       = st_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    lk_we        = 1'b0;
    lk_waddr     = n_r;
    lk_wdata     = head_r;
    lk_re        = 1'b0;
    lk_raddr     = head_r;
    vl_we        = 1'b0;
    vl_waddr     = n_r;
    vl_wdata     = val_r;
    vl_re        = 1'b0;
    vl_raddr     = head_r;
    fcmd         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        st_nxt    = ST_OK;
        state_nxt = S_RESP;
        case (op_r)
          OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else if (pos_ext == '0 || pos_ext > cnt_p1) begin
              st_nxt = ST_BADPOS;
            end else if (pos_ext == (CNT_W + 1)'(1) || empty) begin
              // new head: link it to the old head, with no walk
              lk_we          = 1'b1;
              lk_waddr       = free_idx;
              lk_wdata       = head_r;
              vl_we          = 1'b1;
              vl_waddr       = free_idx;
              vl_wdata       = val_r;
              fcmd.alloc     = 1'b1;
              fcmd.alloc_idx = free_idx;
              head_nxt       = free_idx;
              count_nxt      = count_r + CNT_W'(1);
            end else begin
              n_nxt       = free_idx;
              p_nxt       = head_r;
              rd_pend_nxt = 1'b0;
              steps_nxt   = CNT_W'(pos_ext - (CNT_W + 1)'(2));
              state_nxt   = S_WALK;
            end
          end
          OP_DEL_HEAD: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else if (count_r == CNT_W'(1)) begin
              fcmd.rel     = 1'b1;
              fcmd.rel_idx = head_r;
              head_nxt     = '0;
              count_nxt    = '0;
            end else begin
              lk_re     = 1'b1;
              lk_raddr  = head_r;
              state_nxt = S_HEAD;
            end
          end
          OP_DEL_TAIL: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else if (count_r == CNT_W'(1)) begin
              fcmd.rel     = 1'b1;
              fcmd.rel_idx = head_r;
              head_nxt     = '0;
              count_nxt    = '0;
            end else begin
              p_nxt       = head_r;
              rd_pend_nxt = 1'b0;
              steps_nxt   = count_r - CNT_W'(2);
              state_nxt   = S_WALK;
            end
          end
          OP_READ_OUT: begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              lk_re     = 1'b1;
              lk_raddr  = head_r;
              vl_re     = 1'b1;
              vl_raddr  = head_r;
              steps_nxt = count_r;
              state_nxt = S_RDATA;
            end
          end
          default: begin
            st_nxt = ST_OK;
          end
        endcase
      end

      // one link per cycle; the final read fetches the link of the target
      S_WALK: begin
        lk_re       = 1'b1;
        lk_raddr    = walk_cur;
        p_nxt       = walk_cur;
        rd_pend_nxt = 1'b1;
        if (steps_r == '0) begin
          state_nxt = S_LINK;
        end else begin
          steps_nxt = steps_r - CNT_W'(1);
        end
      end

      S_LINK: begin
        if (op_r == OP_DEL_TAIL) begin
          // lk_rdata is the old tail
          fcmd.rel     = 1'b1;
          fcmd.rel_idx = lk_rdata;
          lk_we        = 1'b1;
          lk_waddr     = p_r;
          lk_wdata     = '0;
          count_nxt    = count_r - CNT_W'(1);
          st_nxt       = ST_OK;
          state_nxt    = S_RESP;
        end else begin
          lk_we     = 1'b1;
          lk_waddr  = n_r;
          lk_wdata  = lk_rdata;
          vl_we     = 1'b1;
          vl_waddr  = n_r;
          vl_wdata  = val_r;
          state_nxt = S_FIX;
        end
      end

      // slot is claimed in the same cycle the count grows
      S_FIX: begin
        lk_we          = 1'b1;
        lk_waddr       = p_r;
        lk_wdata       = n_r;
        fcmd.alloc     = 1'b1;
        fcmd.alloc_idx = n_r;
        count_nxt      = count_r + CNT_W'(1);
        st_nxt         = ST_OK;
        state_nxt      = S_RESP;
      end

      S_HEAD: begin
        fcmd.rel     = 1'b1;
        fcmd.rel_idx = head_r;
        head_nxt     = lk_rdata;
        count_nxt    = count_r - CNT_W'(1);
        st_nxt       = ST_OK;
        state_nxt    = S_RESP;
      end

      // stream elements; a stalled output simply holds the read data
      S_RDATA: begin
        if (out_ready) begin
          out_load                 = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.out_value   = vl_rdata;
          out_data_nxt.entry_count = count_r;
          out_data_nxt.last        = (steps_r == CNT_W'(1));
          if (steps_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            lk_re     = 1'b1;
            lk_raddr  = lk_rdata;
            vl_re     = 1'b1;
            vl_raddr  = lk_rdata;
            steps_nxt = steps_r - CNT_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_ready) begin
          out_load                 = 1'b1;
          out_data_nxt.status      = st_r;
          out_data_nxt.out_value   = '0;
          out_data_nxt.entry_count = count_r;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      val_r <= in_data.item_value;
    end
    p_r        <= p_nxt;
    steps_r    <= steps_nxt;
    n_r        <= n_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  `BOLE_ASSERT_NOW(a_count_matches_free, clk, rst_n, 1'b1,
    ($countones(free_vec) + int'(count_r)) == CAPACITY,
    "element count disagrees with free map")
  `BOLE_ASSERT_NEXT(a_accept_decides, clk, rst_n, in_xfer,
    state_r == S_DECIDE, "accepted operation not decoded next cycle")
  `BOLE_ASSERT_NEXT(a_fix_grows, clk, rst_n, state_r == S_FIX,
    count_r == $past(count_r) + CNT_W'(1), "linked insert did not grow the list")
  `BOLE_ASSERT_NOW(a_last_ends_op, clk, rst_n, out_load && out_data_nxt.last,
    state_nxt == S_IDLE, "final result loaded while operation continues")

endmodule

### dv/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 1ps
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  // opcodes the engine does not define: answered with ok, list untouched
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int unsigned RANDOM_OPS = 330;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct {
    in_item_t  op;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // mirror of the list contents, head first
  logic signed [VAL_W-1:0] list_mirror[$];
  // results still owed by the engine, oldest first
  out_item_t pending_results[$];

  int unsigned errors = 0;
  int unsigned ops_accepted = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_off = 1'b0;
  bit          filling = 1'b1;

  bounded_ordered_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one operation to the mirror and list the results it must produce
  function automatic void apply_list_op(input in_item_t op, output out_item_t res[$]);
    out_item_t   r;
    int unsigned n;
    n = list_mirror.size();
    res = {};
    r = '{status: ST_OK, out_value: '0, entry_count: '0, last: 1'b1};
    case (op.opcode)
      OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT: begin
        // full is reported ahead of a bad position
        if (n >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op.opcode == OP_ADD_HEAD) begin
          list_mirror.push_front(op.item_value);
        end else if (op.opcode == OP_ADD_TAIL) begin
          list_mirror.push_back(op.item_value);
        end else if (op.position < 1 || op.position > n + 1) begin
          r.status = ST_BADPOS;
        end else begin
          list_mirror.insert(int'(op.position) - 1, op.item_value);
        end
      end
      OP_DEL_HEAD: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(list_mirror.pop_front());
      end
      OP_DEL_TAIL: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(list_mirror.pop_back());
      end
      OP_READ_OUT: begin
        // one transfer per element, last set on the tail
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          foreach (list_mirror[k]) begin
            r.out_value   = list_mirror[k];
            r.entry_count = CNT_W'(n);
            r.last        = (k == n - 1);
            res.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(list_mirror.size());
    res.push_back(r);
  endfunction

  // random operation: fill bursts run the list up to full, drain bursts
  // run it back to empty, with reads, noise and bad positions mixed in
  function automatic in_item_t next_random_op();
    in_item_t    op;
    int unsigned n;
    int unsigned r;
    n = list_mirror.size();
    if (filling && n >= CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
    else if (!filling && n == 0 && $urandom_range(3) == 0) filling = 1'b1;
    op.item_value = $urandom();
    op.position   = 6'($urandom_range(63));
    r = $urandom_range(99);
    if (r < 4) begin
      op.opcode = r[0] ? OP_UNUSED_7 : OP_UNUSED_6;
    end else if (r < 10) begin
      op.opcode = OP_READ_OUT;
    end else if ((r < 20) == filling) begin
      op.opcode = $urandom_range(1) ? OP_DEL_TAIL : OP_DEL_HEAD;
    end else begin
      case ($urandom_range(2))
        0: op.opcode = OP_ADD_HEAD;
        1: op.opcode = OP_ADD_TAIL;
        default: op.opcode = OP_INSERT;
      endcase
      // mostly legal positions, the rest anywhere in the field
      if ($urandom_range(4) != 0) op.position = 6'($urandom_range(n + 1, 1));
    end
    return op;
  endfunction

  function automatic dir_row_t row(logic [2:0] opc, logic [5:0] pos,
                                   logic [31:0] val, bit typed,
                                   logic [1:0] st, logic [5:0] cnt);
    dir_row_t d;
    d.op    = '{opcode: opc, position: pos, item_value: val};
    d.typed = typed;
    d.want  = '{status: st, out_value: '0, entry_count: cnt, last: 1'b1};
    return d;
  endfunction

  // offer one operation, wait for its transfer, then record what it owes;
  // valid is only lowered when a gap follows, never dropped and re-raised
  task automatic send_op(input in_item_t op, input bit typed, input out_item_t want);
    out_item_t   res[$];
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(op, res);
    if (typed) pending_results.push_back(want);
    else foreach (res[k]) pending_results.push_back(res[k]);
    ops_accepted++;
  endtask

  task automatic note_error(input string what, input out_item_t want,
                            input out_item_t got);
    errors++;
    if (errors <= 10) begin
      $display("%t: %s: want st=%0d val=%0d cnt=%0d last=%0b, got st=%0d val=%0d cnt=%0d last=%0b",
               $realtime, what, want.status, want.out_value, want.entry_count, want.last,
               got.status, got.out_value, got.entry_count, got.last);
    end
  endtask

  // compare each result transfer with the oldest owed result
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      note_error("result with nothing owed", '0, got);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.out_value !== want.out_value ||
          got.entry_count !== want.entry_count || got.last !== want.last) begin
        note_error("result mismatch", want, got);
      end
    end
  endtask

  // receiver: sample transfers at the edge, pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off while the sender keeps offering, so the engine
  // backs up and stalls its input
  initial begin : pressure_hold
    int unsigned held;
    wait (ops_accepted >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // hard stop in case the engine hangs
  initial begin : watchdog
    #1_000_000;
    $display("bounded_ordered_list_engine regression: fail");
    $finish;
  end

  initial begin : stimulus
    dir_row_t    dir_rows[25];
    in_item_t    op;
    int unsigned n_random;
    int unsigned phase;

    // directed: empty-list cases, position limits, unused opcodes, value
    // extremes, single-element tail delete; reads checked by the mirror
    dir_rows = '{
      row(OP_READ_OUT, 6'd0,  32'd0,         1, ST_EMPTY,  6'd0),
      row(OP_DEL_HEAD, 6'd0,  32'd0,         1, ST_EMPTY,  6'd0),
      row(OP_DEL_TAIL, 6'd0,  32'd0,         1, ST_EMPTY,  6'd0),
      row(OP_INSERT,   6'd0,  32'd1,         1, ST_BADPOS, 6'd0),
      row(OP_INSERT,   6'd2,  32'd1,         1, ST_BADPOS, 6'd0),
      row(OP_UNUSED_6, 6'd63, 32'hFFFF_FFFF, 1, ST_OK,     6'd0),
      row(OP_UNUSED_7, 6'd1,  32'h1234_5678, 1, ST_OK,     6'd0),
      row(OP_ADD_HEAD, 6'd0,  32'h7FFF_FFFF, 1, ST_OK,     6'd1),
      row(OP_ADD_TAIL, 6'd63, 32'h8000_0000, 1, ST_OK,     6'd2),
      row(OP_INSERT,   6'd63, 32'd7,         1, ST_BADPOS, 6'd2),
      row(OP_INSERT,   6'd4,  32'd7,         1, ST_BADPOS, 6'd2),
      row(OP_INSERT,   6'd3,  32'd0,         1, ST_OK,     6'd3),
      row(OP_INSERT,   6'd1,  32'hFFFF_FFFF, 1, ST_OK,     6'd4),
      row(OP_INSERT,   6'd2,  32'h5555_5555, 1, ST_OK,     6'd5),
      row(OP_READ_OUT, 6'd0,  32'd0,         0, ST_OK,     6'd5),
      row(OP_DEL_TAIL, 6'd0,  32'd0,         1, ST_OK,     6'd4),
      row(OP_DEL_HEAD, 6'd0,  32'd0,         1, ST_OK,     6'd3),
      row(OP_READ_OUT, 6'd0,  32'd0,         0, ST_OK,     6'd3),
      row(OP_ADD_HEAD, 6'd0,  32'hAAAA_AAAA, 1, ST_OK,     6'd4),
      row(OP_DEL_TAIL, 6'd0,  32'd0,         1, ST_OK,     6'd3),
      row(OP_DEL_HEAD, 6'd0,  32'd0,         1, ST_OK,     6'd2),
      row(OP_DEL_TAIL, 6'd0,  32'd0,         1, ST_OK,     6'd1),
      row(OP_DEL_TAIL, 6'd0,  32'd0,         1, ST_OK,     6'd0),
      row(OP_ADD_TAIL, 6'd0,  32'h0000_0001, 1, ST_OK,     6'd1),
      row(OP_READ_OUT, 6'd0,  32'd0,         0, ST_OK,     6'd1)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) send_op(dir_rows[k].op, dir_rows[k].typed, dir_rows[k].want);

    // random part in four quarters: no idling, sender idle, receiver
    // stalling, both idling now and then; unused opcodes do not count
    n_random = 0;
    while (n_random < RANDOM_OPS) begin
      phase = n_random * 4 / RANDOM_OPS;
      idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 20 : 0;
      stall_pct = (phase == 2) ? 87 : (phase == 3) ? 20 : 0;
      op = next_random_op();
      send_op(op, 1'b0, '0);
      if (op.opcode <= OP_READ_OUT) n_random++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // catch any stray transfer after the last owed one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("bounded_ordered_list_engine regression: pass");
    end else begin
      $display("bounded_ordered_list_engine regression: fail");
    end
    $finish;
  end

endmodule
